// ----- hw/rtl/parm_pkg.sv -----
// ----------------------------------------------------------------------------
// parm_pkg
// Shared types and constants for the priority address range map.
// ----------------------------------------------------------------------------
package parm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [63:0]      ADDR_TOP  = 64'hffff_ffff_ffff_ffff;

   localparam logic [1:0] OP_TOP    = 2'd0;
   localparam logic [1:0] OP_UNDER  = 2'd1;
   localparam logic [1:0] OP_CUT    = 2'd2;
   localparam logic [1:0] OP_LOOKUP = 2'd3;

   typedef struct packed {
      logic [63:0] addr_lo;
      logic [63:0] addr_hi;
      logic [31:0] tag;
   } parm_entry_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] range_start;
      logic [63:0] range_end;
      logic [31:0] map_id;
   } parm_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] found_id;
      logic        hit;
      logic        status;
   } parm_rsp_type;

   typedef struct packed {
      logic             rd_bank;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic             wr_bank;
      logic [IDX_W-1:0] wr_addr;
      parm_entry_type   wr_data;
   } parm_mem_req_type;

endpackage

// ----- hw/rtl/priority_address_range_map_core.sv -----
// ----------------------------------------------------------------------------
// priority_address_range_map_core
// Sorted table of disjoint address ranges with insert, cut and lookup.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the req_ stream; each gives exactly one beat on
// the rsp_ stream. Insert on top, insert underneath and cut out rebuild the
// table: every pass reads the current bank entry by entry (a read state
// issues the read, an evaluate state works the entry, and a further state
// writes the second piece when an entry yields two) and writes the edited
// table into the other bank, then the banks swap. Insert on top runs a cut
// pass and a fill pass, and a span that wraps past the top doubles the passes.
// A lookup stops at the first entry that answers. One request is worked at
// a time. The result waits in an output register; the next request is taken
// while it waits, and a finished request holds in the engine until the
// register frees. Reset empties the table at once (count cleared, no
// clearing pass).
// ----------------------------------------------------------------------------
module priority_address_range_map_core
   import parm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], range_start[65:2], range_end[129:66], map_id[161:130]
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found_id[31:0], hit[32], status[33]
   output logic [39:0]  rsp_tdata
);

   parm_cmd_type     cmd;
   parm_mem_req_type mem_req;
   parm_entry_type   rd_data;
   parm_rsp_type     eng_rsp;
   logic             eng_idle;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [39:0]      rsp_data_ff, rsp_data_in;

   assign cmd.operation   = req_tdata[1:0];
   assign cmd.range_start = req_tdata[65:2];
   assign cmd.range_end   = req_tdata[129:66];
   assign cmd.map_id      = req_tdata[161:130];

   assign req_tready = eng_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   parm_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   parm_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && req_tready),
      .cmd      (cmd),
      .out_free (out_free),
      .rd_data  (rd_data),
      .mem_req  (mem_req),
      .rsp      (eng_rsp),
      .idle     (eng_idle)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_rsp.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, eng_rsp.status, eng_rsp.hit, eng_rsp.found_id};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("engine idle right after accepting a beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      eng_rsp.done |-> out_free)
      else $error("result written over a waiting beat");

   a_hit_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> !rsp_tdata[33])
      else $error("lookup hit with drop status");

endmodule

// ----- hw/rtl/parm_table.sv -----
// ----------------------------------------------------------------------------
// parm_table
// Two banks of range entries; one bank is read while the other is rebuilt.
// ----------------------------------------------------------------------------
module parm_table
   import parm_pkg::*;
(
   input  logic             clock,
   input  parm_mem_req_type mem_req,
   output parm_entry_type   rd_data
);

   parm_entry_type bank0 [TABLE_DEPTH];
   parm_entry_type bank1 [TABLE_DEPTH];
   parm_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         if (mem_req.wr_bank) begin
            bank1[mem_req.wr_addr] <= mem_req.wr_data;
         end else begin
            bank0[mem_req.wr_addr] <= mem_req.wr_data;
         end
      end
      rd_data_ff <= mem_req.rd_bank ? bank1[mem_req.rd_addr] : bank0[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/parm_engine.sv -----
// ----------------------------------------------------------------------------
// parm_engine
// Walks the sorted table one entry at a time and streams the edited table
// into the other bank; lookups walk without writing.
// ----------------------------------------------------------------------------
module parm_engine
   import parm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  parm_cmd_type     cmd,
   input  logic             out_free,
   input  parm_entry_type   rd_data,
   output parm_mem_req_type mem_req,
   output parm_rsp_type     rsp,
   output logic             idle
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INIT = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_E2   = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic           bank_ff, bank_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] ocnt_ff, ocnt_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [63:0]    c_ff, c_in;
   logic           act_ff, act_in;
   logic           span_ff, span_in;
   logic           phase_ff, phase_in;
   logic           stat_ff, stat_in;
   logic [31:0]    id_ff, id_in;
   logic           hit_ff, hit_in;
   parm_cmd_type   cmd_ff, cmd_in;
   parm_entry_type pend_ff, pend_in;

   logic           wrap;
   logic [63:0]    span_f, span_l;
   parm_entry_type em0, em1, piece;
   logic           em0_v, em1_v, piece_v, lo_v, up_v;

   assign wrap   = cmd_ff.range_end < cmd_ff.range_start;
   assign span_f = span_ff ? 64'd0 : cmd_ff.range_start;
   assign span_l = span_ff ? cmd_ff.range_end : (wrap ? ADDR_TOP : cmd_ff.range_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff   <= idx_in;
      ocnt_ff  <= ocnt_in;
      cur_ff   <= cur_in;
      c_ff     <= c_in;
      act_ff   <= act_in;
      span_ff  <= span_in;
      phase_ff <= phase_in;
      stat_ff  <= stat_in;
      id_ff    <= id_in;
      hit_ff   <= hit_in;
      cmd_ff   <= cmd_in;
      pend_ff  <= pend_in;
   end

   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      ocnt_in  = ocnt_ff;
      cur_in   = cur_ff;
      c_in     = c_ff;
      act_in   = act_ff;
      span_in  = span_ff;
      phase_in = phase_ff;
      stat_in  = stat_ff;
      id_in    = id_ff;
      hit_in   = hit_ff;
      cmd_in   = cmd_ff;
      pend_in  = pend_ff;

      em0 = rd_data;
      em1 = rd_data;
      em0_v = 1'b0;
      em1_v = 1'b0;
      piece = '{addr_lo: c_ff, addr_hi: span_l, tag: cmd_ff.map_id};
      piece_v = 1'b0;
      lo_v = 1'b0;
      up_v = 1'b0;

      mem_req.rd_bank = bank_ff;
      mem_req.rd_addr = idx_ff[IDX_W-1:0];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_bank = ~bank_ff;
      mem_req.wr_addr = ocnt_ff[IDX_W-1:0];
      mem_req.wr_data = rd_data;

      rsp.done     = 1'b0;
      rsp.found_id = id_ff;
      rsp.hit      = hit_ff;
      rsp.status   = stat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               span_in  = 1'b0;
               phase_in = (cmd.operation == OP_UNDER);
               stat_in  = 1'b0;
               id_in    = '0;
               hit_in   = 1'b0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            idx_in   = '0;
            ocnt_in  = '0;
            cur_in   = cnt_ff;
            c_in     = span_f;
            act_in   = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            if (idx_ff == cnt_ff) begin
               state_in = (cmd_ff.operation == OP_LOOKUP) ? S_DONE : S_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_EV;
            end
         end
         S_EV: begin
            state_in = S_RD;
            if (cmd_ff.operation == OP_LOOKUP) begin
               if (rd_data.addr_hi >= cmd_ff.range_start) begin
                  id_in    = rd_data.tag;
                  hit_in   = rd_data.addr_lo <= cmd_ff.range_start;
                  state_in = S_DONE;
               end
            end else if (!phase_ff) begin
               // cut pass
               if (rd_data.addr_hi < span_f || rd_data.addr_lo > span_l) begin
                  em0_v = 1'b1;
               end else begin
                  lo_v = rd_data.addr_lo < span_f;
                  up_v = rd_data.addr_hi > span_l && (!lo_v || cnt_ff < DEPTH_CNT);
                  if (lo_v && rd_data.addr_hi > span_l && cnt_ff >= DEPTH_CNT) begin
                     stat_in = 1'b1;
                  end
                  em1 = '{addr_lo: span_l + 64'd1, addr_hi: rd_data.addr_hi, tag: rd_data.tag};
                  em0 = lo_v ? '{addr_lo: rd_data.addr_lo, addr_hi: span_f - 64'd1,
                                 tag: rd_data.tag} : em1;
                  em0_v = lo_v || up_v;
                  em1_v = lo_v && up_v;
               end
            end else begin
               // gap-fill pass
               if (!act_ff || rd_data.addr_hi < span_f) begin
                  em0_v = 1'b1;
               end else begin
                  if (rd_data.addr_lo > span_l) begin
                     act_in = 1'b0;
                     piece  = '{addr_lo: c_ff, addr_hi: span_l, tag: cmd_ff.map_id};
                     if (cur_ff < DEPTH_CNT) begin
                        piece_v = 1'b1;
                     end else begin
                        stat_in = 1'b1;
                     end
                  end else begin
                     piece = '{addr_lo: c_ff, addr_hi: rd_data.addr_lo - 64'd1,
                               tag: cmd_ff.map_id};
                     if (rd_data.addr_lo > c_ff) begin
                        if (cur_ff < DEPTH_CNT) begin
                           piece_v = 1'b1;
                        end else begin
                           stat_in = 1'b1;
                        end
                     end
                     if (rd_data.addr_hi >= span_l) begin
                        act_in = 1'b0;
                     end else begin
                        c_in = rd_data.addr_hi + 64'd1;
                     end
                  end
                  if (piece_v) begin
                     cur_in = cur_ff + 1'b1;
                  end
                  em0   = piece_v ? piece : rd_data;
                  em0_v = 1'b1;
                  em1   = rd_data;
                  em1_v = piece_v;
               end
            end
            if (em0_v) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = em0;
               ocnt_in         = ocnt_ff + 1'b1;
            end
            if (em1_v) begin
               pend_in  = em1;
               state_in = S_E2;
            end
         end
         S_E2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = pend_ff;
            ocnt_in         = ocnt_ff + 1'b1;
            state_in        = S_RD;
         end
         S_FIN: begin
            cnt_in = ocnt_ff;
            if (phase_ff && act_ff) begin
               if (cur_ff < DEPTH_CNT) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = '{addr_lo: c_ff, addr_hi: span_l, tag: cmd_ff.map_id};
                  cnt_in          = ocnt_ff + 1'b1;
               end else begin
                  stat_in = 1'b1;
               end
            end
            bank_in = ~bank_ff;
            if (cmd_ff.operation == OP_TOP && !phase_ff) begin
               phase_in = 1'b1;
               state_in = S_INIT;
            end else if (!span_ff && wrap) begin
               span_in  = 1'b1;
               phase_in = (cmd_ff.operation == OP_UNDER);
               state_in = S_INIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == S_IDLE);

endmodule

// ----- test/priority_address_range_map_checker.sv -----
// ----------------------------------------------------------------------------
// priority_address_range_map_checker
// Watches the request and response streams, keeps its own copy of the range
// table, and compares every response beat with the predicted one.
// ----------------------------------------------------------------------------
module priority_address_range_map_checker
   import parm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] found_id;
      logic        hit;
      logic        status;
   } answer_type;

   logic [63:0] tbl_first [TABLE_DEPTH];
   logic [63:0] tbl_last  [TABLE_DEPTH];
   logic [31:0] tbl_tag   [TABLE_DEPTH];
   int          tbl_count;
   answer_type  answer_q [$];

   function automatic int find_slot(logic [63:0] a);
      int i;
      i = 0;
      while (i < tbl_count && tbl_last[i] < a) i++;
      return i;
   endfunction

   function automatic bit place(int i, logic [63:0] f, logic [63:0] l, logic [31:0] t);
      if (tbl_count >= TABLE_DEPTH || i > tbl_count) return 0;
      for (int j = tbl_count; j > i; j--) begin
         tbl_first[j] = tbl_first[j-1];
         tbl_last[j]  = tbl_last[j-1];
         tbl_tag[j]   = tbl_tag[j-1];
      end
      tbl_first[i] = f;
      tbl_last[i]  = l;
      tbl_tag[i]   = t;
      tbl_count++;
      return 1;
   endfunction

   function automatic void remove(int i);
      for (int j = i; j < tbl_count - 1; j++) begin
         tbl_first[j] = tbl_first[j+1];
         tbl_last[j]  = tbl_last[j+1];
         tbl_tag[j]   = tbl_tag[j+1];
      end
      tbl_count--;
   endfunction

   function automatic bit carve(logic [63:0] f, logic [63:0] l);
      int          i;
      logic [63:0] up;
      i = find_slot(f);
      while (i < tbl_count) begin
         if (tbl_first[i] < f) begin
            if (tbl_last[i] > l) begin
               up = tbl_last[i];
               tbl_last[i] = f - 1;
               return place(i + 1, l + 1, up, tbl_tag[i]);
            end
            tbl_last[i] = f - 1;
            i++;
         end else if (tbl_last[i] <= l) begin
            remove(i);
         end else begin
            if (tbl_first[i] <= l) tbl_first[i] = l + 1;
            break;
         end
      end
      return 1;
   endfunction

   function automatic bit fill_gaps(logic [63:0] f, logic [63:0] l, logic [31:0] t);
      bit          ok;
      logic [63:0] c;
      int          i;
      ok = 1;
      c  = f;
      i  = find_slot(f);
      while (i < tbl_count && tbl_first[i] <= l) begin
         if (tbl_first[i] > c) begin
            if (place(i, c, tbl_first[i] - 1, t)) i++;
            else ok = 0;
         end
         if (tbl_last[i] >= l) return ok;
         c = tbl_last[i] + 1;
         i++;
      end
      if (!place(i, c, l, t)) ok = 0;
      return ok;
   endfunction

   function automatic answer_type apply_request(parm_cmd_type cmd);
      answer_type  ans;
      logic [63:0] f [2];
      logic [63:0] l [2];
      int          n, i;
      bit          ok, r;
      ans = '0;
      ok  = 1;
      if (cmd.operation == OP_LOOKUP) begin
         i = find_slot(cmd.range_start);
         if (i < tbl_count) begin
            ans.found_id = tbl_tag[i];
            ans.hit      = tbl_first[i] <= cmd.range_start;
         end
      end else begin
         // a wrapping span is worked as its upper part, then its lower part
         f[0] = cmd.range_start;
         if (cmd.range_end < cmd.range_start) begin
            l[0] = ADDR_TOP; f[1] = '0; l[1] = cmd.range_end; n = 2;
         end else begin
            l[0] = cmd.range_end; n = 1;
         end
         for (int k = 0; k < n; k++) begin
            case (cmd.operation)
               OP_TOP: begin
                  r = carve(f[k], l[k]);
                  if (!place(find_slot(f[k]), f[k], l[k], cmd.map_id)) r = 0;
               end
               OP_UNDER: r = fill_gaps(f[k], l[k], cmd.map_id);
               default:  r = carve(f[k], l[k]);
            endcase
            if (!r) ok = 0;
         end
      end
      ans.status = !ok;
      return ans;
   endfunction

   assign pending_count = answer_q.size();

   always @(posedge clock) begin
      parm_cmd_type cmd;
      answer_type   got, want;
      if (reset) begin
         tbl_count = 0;
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            cmd.operation   = req_tdata[1:0];
            cmd.range_start = req_tdata[65:2];
            cmd.range_end   = req_tdata[129:66];
            cmd.map_id      = req_tdata[161:130];
            answer_q.push_back(apply_request(cmd));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found_id = rsp_tdata[31:0];
            got.hit      = rsp_tdata[32];
            got.status   = rsp_tdata[33];
            if (answer_q.size() == 0) begin
               $error("response beat with no request waiting");
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (got.found_id !== want.found_id) begin
                  $error("found_id expected %h actual %h", want.found_id, got.found_id);
                  fail_count++;
               end
               if (got.hit !== want.hit) begin
                  $error("hit expected %b actual %b", want.hit, got.hit);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %b actual %b", want.status, got.status);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ----- test/tb_priority_address_range_map_core.sv -----
// ----------------------------------------------------------------------------
// tb_priority_address_range_map_core
// Drives directed and random insert, cut and lookup beats with random gaps
// and response stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_priority_address_range_map_core;
   import parm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [39:0]  rsp_tdata;
   int           fail_count;
   int           pending_count;
   bit           stim_done = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   priority_address_range_map_core dut (.*);

   priority_address_range_map_checker checker_i (.*);

   logic [63:0] hot_addr [8];

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // addresses cluster around a few points so spans overlap often
   function automatic logic [63:0] pick_addr();
      case ($urandom_range(0, 5))
         0:       return rand64();
         1:       return $urandom_range(0, 3) == 0 ? 64'd0 : ADDR_TOP;
         default: return hot_addr[$urandom_range(0, 7)] + 64'($urandom_range(0, 255)) - 64'd128;
      endcase
   endfunction

   task automatic send_beat(logic [1:0] op, logic [63:0] s, logic [63:0] e, logic [31:0] id);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, id, e, s, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // response side stalls a random number of cycles per beat
   initial begin
      @(negedge reset);
      forever begin
         int gap;
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      logic [63:0] s, e;
      logic [1:0]  op;
      for (int i = 0; i < 8; i++) hot_addr[i] = rand64();
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: empty lookups, extremes, splits, wraps, odd ids
      send_beat(OP_LOOKUP, 64'd0, 64'd0, 32'd1);
      send_beat(OP_LOOKUP, ADDR_TOP, 64'd0, 32'd1);
      send_beat(OP_TOP, 64'd100, 64'd200, 32'd1);
      send_beat(OP_TOP, 64'd150, 64'd160, 32'd2);
      send_beat(OP_LOOKUP, 64'd155, 64'd0, 32'd0);
      send_beat(OP_LOOKUP, 64'd170, 64'd0, 32'd0);
      send_beat(OP_LOOKUP, 64'd50, 64'd0, 32'd0);
      send_beat(OP_UNDER, 64'd0, 64'd300, 32'd3);
      send_beat(OP_CUT, 64'd120, 64'd130, 32'd0);
      send_beat(OP_TOP, ADDR_TOP - 10, 64'd5, 32'hffff_fffe);
      send_beat(OP_UNDER, ADDR_TOP - 20, 64'd20, 32'hffff_ffff);
      send_beat(OP_LOOKUP, ADDR_TOP, 64'd0, 32'd0);
      send_beat(OP_TOP, 64'd400, 64'd400, 32'd0);
      send_beat(OP_LOOKUP, 64'd400, 64'd0, 32'd0);
      send_beat(OP_CUT, ADDR_TOP - 5, 64'd2, 32'd0);
      send_beat(OP_CUT, 64'd0, ADDR_TOP, 32'd0);
      send_beat(OP_UNDER, 64'd0, ADDR_TOP, 32'hffff_ffff);
      send_beat(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 32'd0);
      // fill the table to force drops, then split a range with no slot left
      for (int i = 0; i < 70; i++)
         send_beat(OP_TOP, 64'(i) * 64'd10, 64'(i) * 64'd10 + 64'd4, 32'(i + 1));
      send_beat(OP_CUT, 64'd1, 64'd2, 32'd0);
      send_beat(OP_UNDER, 64'd0, 64'd1000, 32'd9);
      send_beat(OP_LOOKUP, 64'd7, 64'd0, 32'd0);
      send_beat(OP_CUT, 64'd0, ADDR_TOP, 32'd0);
      for (int n = 0; n < 1450; n++) begin
         op = 2'($urandom_range(0, 3));
         s  = pick_addr();
         case ($urandom_range(0, 9))
            0:       e = rand64();
            1:       e = s - 64'($urandom_range(1, 300));
            default: e = s + 64'($urandom_range(0, 400));
         endcase
         // occasional wipe keeps the table from sitting full
         if ($urandom_range(0, 99) == 0) begin
            op = OP_CUT; s = 64'd0; e = ADDR_TOP;
         end
         send_beat(op, s, e, $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(1, 20));
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("** priority_address_range_map_core: PASSED **");
      end else begin
         $display("** priority_address_range_map_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("** priority_address_range_map_core: FAILED **");
      $finish;
   end
endmodule

// ----- priority_address_range_map_core.f -----
hw/rtl/parm_pkg.sv
hw/rtl/parm_table.sv
hw/rtl/parm_engine.sv
hw/rtl/priority_address_range_map_core.sv
test/priority_address_range_map_checker.sv
test/tb_priority_address_range_map_core.sv
